>>> sv/gdc_pkg.sv
// shared constants and types for the grid distortion correction core
package gdc_pkg;

	localparam int GRID_W      = 7;
	localparam int GRID_POINTS = 1 << GRID_W;
	localparam int FRAC_BITS   = 9;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = COORD_BITS - FRAC_BITS;
	localparam int ENTRY_W     = 16;
	localparam int CELL_W      = 2 * ENTRY_W;
	localparam int BANK_W      = GRID_W - 1;
	localparam int BANK_AW     = 2 * BANK_W;
	localparam int BANK_DEPTH  = 1 << BANK_AW;
	localparam int N_BANKS     = 4;
	localparam int DIFF_W      = ENTRY_W + 1;
	localparam int WGT_W       = FRAC_BITS + 1;
	localparam int PROD_W      = DIFF_W + WGT_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int FRAC_MASK   = (1 << FRAC_BITS) - 1;

	typedef enum logic {
		KIND_WRITE   = 1'b0,
		KIND_CORRECT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [GRID_W-1:0]       entry_col;
		logic [GRID_W-1:0]       entry_row;
		logic [ENTRY_W-1:0]      entry_x;
		logic [ENTRY_W-1:0]      entry_y;
		logic [COORD_BITS-1:0]   point_x;
		logic [COORD_BITS-1:0]   point_y;
	} in_beat_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] corrected_x;
		logic [ENTRY_W-1:0] corrected_y;
	} out_beat_t;

	// what travels beside the bank read data into the arithmetic
	typedef struct packed {
		logic                 lower;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic                 col_odd;
		logic                 col_clamp;
		logic                 row_odd;
		logic                 row_clamp;
	} fetch_side_t;

endpackage

>>> sv/gdc_in_if.sv
// input channel of the correction core
interface gdc_in_if import gdc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/gdc_out_if.sv
// output channel of the correction core
interface gdc_out_if import gdc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/grid_distortion_correction_core.sv
// top level of the grid distortion correction core
// a correct beat's result is registered in turn at s1 (the bank read), s2, s3, s4 and s5
// throughput: one beat per clock while the output is not stalled, table writes and corrections alike
// the four corner reads come from four parity banks of the table, one port each
// reset clears only the valid bits; table entries are undefined until written
// write beats update the table in the cycle they are accepted and give no result
module grid_distortion_correction_core import gdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gdc_in_if.sink     req,
	gdc_out_if.source  rsp
);

	logic                           s1_ready;
	logic                           v_s1;
	fetch_side_t                    side_s1;
	logic [N_BANKS-1:0][CELL_W-1:0] bank_s1;

	gdc_fetch u_fetch (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.s1_ready(s1_ready),
		.v_s1    (v_s1),
		.side_s1 (side_s1),
		.bank_s1 (bank_s1)
	);

	gdc_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.side_s1 (side_s1),
		.bank_s1 (bank_s1),
		.s1_ready(s1_ready),
		.rsp     (rsp)
	);

endmodule

>>> sv/gdc_ram.sv
// generic single-write single-read ram with registered read
module gdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/gdc_fetch.sv
// box selection, banked table writes and the four corner reads
module gdc_fetch import gdc_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	gdc_in_if.sink                           req,
	input  logic                             s1_ready,
	output logic                             v_s1,
	output fetch_side_t                      side_s1,
	output logic [N_BANKS-1:0][CELL_W-1:0]   bank_s1
);

	localparam logic [GRID_W-1:0] LAST = GRID_W'(GRID_POINTS - 1);

	logic              en1;
	logic              acc;
	logic              rd_en;
	logic [IDX_W-1:0]  ix_raw, iy_raw;
	logic [GRID_W-1:0] ci, cj, ci1, cj1;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [1:0]        wbank;
	logic [BANK_AW-1:0] waddr;

	assign en1       = !v_s1 || s1_ready;
	assign req.ready = en1;
	assign acc       = req.valid && en1;
	assign rd_en     = acc && (req.data.kind == KIND_CORRECT);

	assign ix_raw = req.data.point_x[COORD_BITS-1:FRAC_BITS];
	assign iy_raw = req.data.point_y[COORD_BITS-1:FRAC_BITS];
	assign fx     = req.data.point_x[FRAC_BITS-1:0];
	assign fy     = req.data.point_y[FRAC_BITS-1:0];

	// box index saturates at the last grid point
	assign ci  = (32'(ix_raw) > 32'(GRID_POINTS - 1)) ? LAST : GRID_W'(ix_raw);
	assign cj  = (32'(iy_raw) > 32'(GRID_POINTS - 1)) ? LAST : GRID_W'(iy_raw);
	assign ci1 = (ci == LAST) ? ci : ci + 1'b1;
	assign cj1 = (cj == LAST) ? cj : cj + 1'b1;

	assign wbank = {req.data.entry_col[0], req.data.entry_row[0]};
	assign waddr = {req.data.entry_col[GRID_W-1:1], req.data.entry_row[GRID_W-1:1]};

	// bank {c,r} holds the entries whose column parity is c and row parity is r
	for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
		localparam logic CP = 1'((b >> 1) & 1);
		localparam logic RP = 1'(b & 1);
		logic [GRID_W-1:0]  rcol, rrow;
		logic [BANK_AW-1:0] raddr;

		assign rcol  = (ci[0] == CP) ? ci : ci1;
		assign rrow  = (cj[0] == RP) ? cj : cj1;
		assign raddr = {rcol[GRID_W-1:1], rrow[GRID_W-1:1]};

		gdc_ram #(
			.WIDTH(CELL_W),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (acc && (req.data.kind == KIND_WRITE) && (wbank == 2'(b))),
			.waddr(waddr),
			.wdata({req.data.entry_x, req.data.entry_y}),
			.re   (rd_en),
			.raddr(raddr),
			.rdata(bank_s1[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			side_s1.lower     <= (fx >= fy);
			side_s1.fx        <= fx;
			side_s1.fy        <= fy;
			side_s1.col_odd   <= ci[0];
			side_s1.col_clamp <= (ci == LAST);
			side_s1.row_odd   <= cj[0];
			side_s1.row_clamp <= (cj == LAST);
		end
	end

endmodule

>>> sv/gdc_interp.sv
// corner routing, differences, products, sums and truncating scale
module gdc_interp import gdc_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_s1,
	input  fetch_side_t                     side_s1,
	input  logic [N_BANKS-1:0][CELL_W-1:0]  bank_s1,
	output logic                            s1_ready,
	gdc_out_if.source                       rsp
);

	logic take2, take3, take4, take5;
	logic v_s2, v_s3, v_s4, v_s5;

	// s1 routing
	logic [1:0]        b00, b10, b01, b11;
	logic              c1p, r1p;
	logic [CELL_W-1:0] c00, c10, c01, c11;
	logic [CELL_W-1:0] a_hi, a_lo, b_hi, b_lo;

	// s2
	logic signed [DIFF_W-1:0] dax_s2, dbx_s2, day_s2, dby_s2;
	logic [ENTRY_W-1:0]       bx_s2, by_s2;
	logic [FRAC_BITS-1:0]     fx_s2, fy_s2;
	logic signed [WGT_W-1:0]  wfx, wfy;

	// s3
	logic signed [PROD_W-1:0] pax_s3, pbx_s3, pay_s3, pby_s3;
	logic [ENTRY_W-1:0]       bx_s3, by_s3;

	// s4
	logic signed [SUM_W-1:0]  sx_s4, sy_s4;
	logic [ENTRY_W-1:0]       bx_s4, by_s4;
	logic signed [SUM_W-1:0]  biased_x, biased_y, qx, qy;

	// s5
	out_beat_t                res_s5;

	assign take5    = !v_s5 || rsp.ready;
	assign take4    = !v_s4 || take5;
	assign take3    = !v_s3 || take4;
	assign take2    = !v_s2 || take3;
	assign s1_ready = take2;

	// the second column or row falls in the other parity bank unless clamped
	assign c1p = side_s1.col_clamp ? side_s1.col_odd : !side_s1.col_odd;
	assign r1p = side_s1.row_clamp ? side_s1.row_odd : !side_s1.row_odd;
	assign b00 = {side_s1.col_odd, side_s1.row_odd};
	assign b10 = {c1p, side_s1.row_odd};
	assign b01 = {side_s1.col_odd, r1p};
	assign b11 = {c1p, r1p};
	assign c00 = bank_s1[b00];
	assign c10 = bank_s1[b10];
	assign c01 = bank_s1[b01];
	assign c11 = bank_s1[b11];

	// both outputs reduce to da*fx + db*fy with the same corner pairs
	assign a_hi = side_s1.lower ? c10 : c11;
	assign a_lo = side_s1.lower ? c00 : c01;
	assign b_hi = side_s1.lower ? c11 : c01;
	assign b_lo = side_s1.lower ? c10 : c00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (take2) begin
				v_s2 <= v_s1;
			end
			if (take3) begin
				v_s3 <= v_s2;
			end
			if (take4) begin
				v_s4 <= v_s3;
			end
			if (take5) begin
				v_s5 <= v_s4;
			end
		end
	end

	assign wfx = {1'b0, fx_s2};
	assign wfy = {1'b0, fy_s2};

	// divide by the fraction scale, rounding toward zero
	assign biased_x = sx_s4 + (sx_s4[SUM_W-1] ? SUM_W'(FRAC_MASK) : SUM_W'(0));
	assign biased_y = sy_s4 + (sy_s4[SUM_W-1] ? SUM_W'(FRAC_MASK) : SUM_W'(0));
	assign qx       = biased_x >>> FRAC_BITS;
	assign qy       = biased_y >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (take2 && v_s1) begin
			dax_s2 <= DIFF_W'(a_hi[CELL_W-1:ENTRY_W]) - DIFF_W'(a_lo[CELL_W-1:ENTRY_W]);
			dbx_s2 <= DIFF_W'(b_hi[CELL_W-1:ENTRY_W]) - DIFF_W'(b_lo[CELL_W-1:ENTRY_W]);
			day_s2 <= DIFF_W'(a_hi[ENTRY_W-1:0]) - DIFF_W'(a_lo[ENTRY_W-1:0]);
			dby_s2 <= DIFF_W'(b_hi[ENTRY_W-1:0]) - DIFF_W'(b_lo[ENTRY_W-1:0]);
			bx_s2  <= c00[CELL_W-1:ENTRY_W];
			by_s2  <= c00[ENTRY_W-1:0];
			fx_s2  <= side_s1.fx;
			fy_s2  <= side_s1.fy;
		end
		if (take3 && v_s2) begin
			pax_s3 <= PROD_W'(dax_s2) * PROD_W'(wfx);
			pbx_s3 <= PROD_W'(dbx_s2) * PROD_W'(wfy);
			pay_s3 <= PROD_W'(day_s2) * PROD_W'(wfx);
			pby_s3 <= PROD_W'(dby_s2) * PROD_W'(wfy);
			bx_s3  <= bx_s2;
			by_s3  <= by_s2;
		end
		if (take4 && v_s3) begin
			sx_s4 <= SUM_W'(pax_s3) + SUM_W'(pbx_s3);
			sy_s4 <= SUM_W'(pay_s3) + SUM_W'(pby_s3);
			bx_s4 <= bx_s3;
			by_s4 <= by_s3;
		end
		if (take5 && v_s4) begin
			res_s5.corrected_x <= bx_s4 + qx[ENTRY_W-1:0];
			res_s5.corrected_y <= by_s4 + qy[ENTRY_W-1:0];
		end
	end

	assign rsp.valid = v_s5;
	assign rsp.data  = res_s5;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_ready |-> (v_s2 && v_s3 && v_s4 && v_s5 && !rsp.ready))
		else $error("stage s1 held back with a bubble downstream");

	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !take5) |=> (v_s4 && $stable(sx_s4) && $stable(sy_s4)))
		else $error("stalled sum stage lost its contents");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && take3) |=> v_s3)
		else $error("beat dropped between s2 and s3");

	a_s1_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && take2) |=> v_s2)
		else $error("beat dropped between s1 and s2");
`endif

endmodule
